[rtl/tsrl_pkg.sv]
// shared types and constants for the timed slew-rate limiter
package tsrl_pkg;

	localparam int VALUE_W        = 32;
	localparam int RATE_W         = 16;
	localparam int TIME_W         = 32;
	localparam int RATE_FRAC_BITS = 8;
	localparam int STATUS_W       = 2;

	localparam int CFG_DATA_W = 32;
	localparam int CFG_ADDR_W = 4;

	// magnitude times rate, then times elapsed ms
	localparam int MP_W   = VALUE_W + RATE_W;
	localparam int PROD_W = MP_W + TIME_W;

	// 100 percent * 1000 ms * 2^frac
	localparam longint DIVISOR = 64'd100000 << RATE_FRAC_BITS;
	localparam int     REM_W   = $clog2(DIVISOR);
	localparam int     STEP_W  = VALUE_W - 1;

	localparam int MUL_STEPS = TIME_W;
	localparam int DIV_STEPS = PROD_W;
	localparam int MUL_CNT_W = $clog2(MUL_STEPS);
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef enum logic [1:0] {
		REG_RATED_VALUE  = 2'd0,
		REG_SLEW_RATE    = 2'd1,
		REG_ENABLE       = 2'd2,
		REG_FIXED_ELAPSED = 2'd3
	} reg_idx_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_SLEWED   = 2'd0,
		ST_CAPTURED = 2'd1,
		ST_BAD_TIME = 2'd2,
		ST_PASSED   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MUL,
		S_DIV,
		S_DONE
	} state_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] rated_value;
		logic [RATE_W-1:0]         slew_rate;
		logic                      enable;
		logic [TIME_W-1:0]         fixed_elapsed_ms;
	} cfg_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage

[rtl/tsrl_cfg_regs.sv]
// configuration register bank behind the apb-style port
module tsrl_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [tsrl_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [tsrl_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [tsrl_pkg::CFG_DATA_W-1:0] prdata,
	output logic                            pready,
	output tsrl_pkg::cfg_t                  cfg
);
	import tsrl_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rated_value      <= '0;
			cfg_q.slew_rate        <= '0;
			cfg_q.enable           <= 1'b1;
			cfg_q.fixed_elapsed_ms <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_RATED_VALUE:   cfg_q.rated_value      <= pwdata[VALUE_W-1:0];
				REG_SLEW_RATE:     cfg_q.slew_rate        <= pwdata[RATE_W-1:0];
				REG_ENABLE:        cfg_q.enable           <= pwdata[0];
				REG_FIXED_ELAPSED: cfg_q.fixed_elapsed_ms <= pwdata[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_RATED_VALUE:   prdata = CFG_DATA_W'(unsigned'(cfg_q.rated_value));
			REG_SLEW_RATE:     prdata = CFG_DATA_W'(cfg_q.slew_rate);
			REG_ENABLE:        prdata = CFG_DATA_W'(cfg_q.enable);
			REG_FIXED_ELAPSED: prdata = CFG_DATA_W'(cfg_q.fixed_elapsed_ms);
			default:           prdata = '0;
		endcase
	end

endmodule

[rtl/tsrl_serial_mul.sv]
// bit-serial shift-add multiplier, one multiplier bit per cycle
module tsrl_serial_mul (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [tsrl_pkg::MP_W-1:0]   mcand,
	input  logic [tsrl_pkg::TIME_W-1:0] mplier,
	output logic [tsrl_pkg::PROD_W-1:0] product,
	output tsrl_pkg::unit_stat_t        stat
);
	import tsrl_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic [MP_W-1:0]      mcand_q;
	logic [PROD_W-1:0]    prod_q;
	logic [MP_W:0]        partial;

	// upper half gains the multiplicand when the low bit is set
	assign partial = {1'b0, prod_q[PROD_W-1:TIME_W]}
		+ (prod_q[0] ? {1'b0, mcand_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= MUL_CNT_W'(MUL_STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q <= mcand;
			prod_q  <= {{MP_W{1'b0}}, mplier};
		end else if (busy_q) begin
			prod_q <= {partial, prod_q[TIME_W-1:1]};
		end
	end

	assign product   = prod_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

[rtl/tsrl_serial_div.sv]
// restoring divider by the fixed rate scale, one quotient bit per cycle, saturating
module tsrl_serial_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [tsrl_pkg::PROD_W-1:0] dividend,
	output logic [tsrl_pkg::STEP_W-1:0] quotient,
	output tsrl_pkg::unit_stat_t        stat
);
	import tsrl_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [PROD_W-1:0]    dvd_q;
	logic [REM_W-1:0]     rem_q;
	logic [STEP_W-1:0]    quo_q;
	logic                 ovf_q;
	logic [REM_W:0]       trial;
	logic                 fits;
	logic [REM_W:0]       diff;

	assign trial = {rem_q, dvd_q[PROD_W-1]};
	assign fits  = trial >= (REM_W + 1)'(DIVISOR);
	assign diff  = trial - (REM_W + 1)'(DIVISOR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[PROD_W-2:0], 1'b0};
			rem_q <= fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
			quo_q <= {quo_q[STEP_W-2:0], fits};
			// any bit pushed past the top means the step saturates
			ovf_q <= ovf_q | quo_q[STEP_W-1];
		end
	end

	assign quotient  = ovf_q ? '1 : quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

[rtl/timed_slew_rate_limiter_core.sv]
// top level of the timed slew-rate limiter: control, held state and result register
//
// Each request brings a millisecond timestamp and a setpoint; one result follows per
// request with the held output value and a status code (0 slewed, 1 time captured,
// 2 bad elapsed time, 3 passed through while disabled). The first request after reset
// only records the time. Later requests use the elapsed time (or fixed_elapsed_ms when
// that register is nonzero, in which case the stored time stays frozen) and move the
// held value toward the setpoint by floor(|rated_value| * slew_rate * elapsed /
// (100 * 1000 * 256)), saturated, without passing it. Requests that capture time,
// report a bad time or pass through go from acceptance straight to the done state.
// A slewed request first forms the step in a bit-serial shift-add multiplier (one bit
// of elapsed time per step) and then in a restoring divider by the constant rate
// scale (one quotient bit per step). One request is in work at a time; the result
// register lets a new request be taken while the previous result waits on a stalled
// output. Configuration writes belong in idle periods only. The apb-style port has
// pready tied high and returns register contents on reads.
module timed_slew_rate_limiter_core (
	input  logic                                clk,
	input  logic                                arst_n,
	// request channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [tsrl_pkg::TIME_W-1:0]         timestamp_ms,
	input  logic signed [tsrl_pkg::VALUE_W-1:0] setpoint,
	// result channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [tsrl_pkg::VALUE_W-1:0] output_value,
	output logic [tsrl_pkg::STATUS_W-1:0]       status,
	// configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [tsrl_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [tsrl_pkg::CFG_DATA_W-1:0]     pwdata,
	output logic [tsrl_pkg::CFG_DATA_W-1:0]     prdata,
	output logic                                pready
);
	import tsrl_pkg::*;

	cfg_t       cfg;
	state_t     state_q, state_nxt;
	unit_stat_t mul_stat, div_stat;

	// held state
	logic [TIME_W-1:0]         last_time_q;
	logic                      time_valid_q;
	logic signed [VALUE_W-1:0] cur_q;

	// request in work
	logic [TIME_W-1:0]         now_q;
	logic signed [VALUE_W-1:0] sp_q;
	status_t                   kind_q;
	logic                      test_q;

	// result register
	logic                      out_valid_q;
	logic signed [VALUE_W-1:0] out_value_q;
	status_t                   out_status_q;

	logic                      in_accept;
	logic                      out_free;
	logic                      commit;
	logic                      mul_start;
	logic                      div_start;

	logic                      test_mode;
	logic [TIME_W-1:0]         elapsed;
	status_t                   kind;
	logic [VALUE_W-1:0]        rated_mag;
	logic [MP_W-1:0]           mag_rate;
	logic [PROD_W-1:0]         product;
	logic [STEP_W-1:0]         step;
	logic signed [VALUE_W+1:0] cur_x, sp_x, step_x, nv_x;
	logic signed [VALUE_W-1:0] new_value;

	tsrl_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// classify the incoming request against the stored time
	assign test_mode = cfg.fixed_elapsed_ms != '0;
	always_comb begin
		if (test_mode)
			elapsed = cfg.fixed_elapsed_ms;
		else if (timestamp_ms > last_time_q)
			elapsed = timestamp_ms - last_time_q;
		else
			elapsed = '0;

		if (!time_valid_q)
			kind = ST_CAPTURED;
		else if (elapsed == '0)
			kind = ST_BAD_TIME;
		else if (!cfg.enable)
			kind = ST_PASSED;
		else
			kind = ST_SLEWED;
	end

	// |rated| as unsigned, so the most negative value maps to 2^31
	assign rated_mag = cfg.rated_value[VALUE_W-1]
		? (~unsigned'(cfg.rated_value) + 1'b1) : unsigned'(cfg.rated_value);
	assign mag_rate  = rated_mag * cfg.slew_rate;

	tsrl_serial_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mcand   (mag_rate),
		.mplier  (elapsed),
		.product (product),
		.stat    (mul_stat)
	);

	tsrl_serial_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (product),
		.quotient (step),
		.stat     (div_stat)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_accept)
					state_nxt = (kind == ST_SLEWED) ? S_MUL : S_DONE;
			end
			S_MUL: begin
				if (mul_stat.done)
					state_nxt = S_DIV;
			end
			S_DIV: begin
				if (div_stat.done)
					state_nxt = S_DONE;
			end
			S_DONE: begin
				if (out_free)
					state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// control outputs
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	always_comb begin
		in_stall  = 1'b1;
		mul_start = 1'b0;
		div_start = 1'b0;
		commit    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_stall  = 1'b0;
				mul_start = in_valid && (kind == ST_SLEWED);
			end
			S_MUL:  div_start = mul_stat.done;
			S_DIV:  ;
			S_DONE: commit = out_free;
			default: ;
		endcase
	end

	// move toward the setpoint without passing it
	always_comb begin
		cur_x  = {{2{cur_q[VALUE_W-1]}}, cur_q};
		sp_x   = {{2{sp_q[VALUE_W-1]}}, sp_q};
		step_x = {3'b000, step};
		if (sp_x < cur_x) begin
			nv_x = cur_x - step_x;
			if (nv_x <= sp_x)
				nv_x = sp_x;
		end else begin
			nv_x = cur_x + step_x;
			if (nv_x >= sp_x)
				nv_x = sp_x;
		end
		new_value = nv_x[VALUE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (in_accept) begin
			now_q  <= timestamp_ms;
			sp_q   <= setpoint;
			kind_q <= kind;
			test_q <= test_mode;
		end
	end

	// held state update at commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q  <= '0;
			time_valid_q <= 1'b0;
			cur_q        <= '0;
		end else if (commit) begin
			case (kind_q)
				ST_CAPTURED: begin
					last_time_q  <= now_q;
					time_valid_q <= 1'b1;
				end
				ST_BAD_TIME: last_time_q <= now_q;
				ST_PASSED: begin
					cur_q <= sp_q;
					if (!test_q)
						last_time_q <= now_q;
				end
				ST_SLEWED: begin
					cur_q <= new_value;
					if (!test_q)
						last_time_q <= now_q;
				end
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_status_q <= kind_q;
			case (kind_q)
				ST_PASSED: out_value_q <= sp_q;
				ST_SLEWED: out_value_q <= new_value;
				default:   out_value_q <= cur_q;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign output_value = out_value_q;
	assign status       = out_status_q;

	// no serial unit runs while the block waits for a request
	a_idle_units_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !mul_stat.busy && !div_stat.busy)
		else $error("serial unit busy while idle");

	// the divider only finishes while the control waits on it
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == S_DIV)
		else $error("divider finished outside divide phase");

	// a committed result is presented on the next cycle
	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> out_valid)
		else $error("committed result not presented");

	// only a slewed request starts the multiplier
	a_mul_only_slew: assert property (@(posedge clk) disable iff (!arst_n)
		mul_start |-> in_accept && time_valid_q && cfg.enable)
		else $error("multiplier started for a request that does not slew");

	// time becomes valid on the first commit and stays valid
	a_time_valid_after: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> time_valid_q)
		else $error("time not valid after commit");

endmodule

[tb/slew_result_checker.sv]
// request/result watcher for the slew-rate limiter: predicts each result and compares
`timescale 1ns / 1ps

module slew_result_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic [tsrl_pkg::TIME_W-1:0]         timestamp_ms,
	input  logic signed [tsrl_pkg::VALUE_W-1:0] setpoint,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic signed [tsrl_pkg::VALUE_W-1:0] output_value,
	input  logic [tsrl_pkg::STATUS_W-1:0]       status,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic                                pready,
	input  logic [tsrl_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [tsrl_pkg::CFG_DATA_W-1:0]     pwdata,
	output int                                  mismatches,
	output int                                  pending,
	output int                                  slewed_seen,
	output int                                  bad_time_seen,
	output int                                  passed_seen,
	output int                                  captured_seen
);
	import tsrl_pkg::*;

	localparam int REPORT_LIMIT = 10;
	localparam longint VALUE_MAX = (longint'(1) << (VALUE_W - 1)) - 1;
	localparam logic [PROD_W-1:0] RATE_SCALE = PROD_W'(100 * 1000) << RATE_FRAC_BITS;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		status_t                   code;
	} slew_result_t;

	slew_result_t expected_q[$];

	cfg_t                      held_cfg;
	logic [TIME_W-1:0]         held_time;
	logic                      held_time_valid;
	logic signed [VALUE_W-1:0] held_value;

	// one step of the limiter, updates the held state
	function automatic slew_result_t slew_next(input logic [TIME_W-1:0] now,
			input logic signed [VALUE_W-1:0] target);
		logic [TIME_W-1:0]  elapsed;
		logic               test_mode;
		logic [VALUE_W-1:0] rated;
		logic [VALUE_W-1:0] mag;
		logic [PROD_W-1:0]  product;
		logic [PROD_W-1:0]  quotient;
		longint             step;
		longint             cur;
		longint             tgt;
		longint             nv;
		slew_result_t       res;
		test_mode = (held_cfg.fixed_elapsed_ms != '0);
		if (!held_time_valid) begin
			held_time = now;
			held_time_valid = 1'b1;
			res.code = ST_CAPTURED;
		end else begin
			if (test_mode)
				elapsed = held_cfg.fixed_elapsed_ms;
			else if (now > held_time)
				elapsed = now - held_time;
			else
				elapsed = '0;
			if (elapsed == '0) begin
				held_time = now;
				res.code = ST_BAD_TIME;
			end else if (!held_cfg.enable) begin
				held_value = target;
				if (!test_mode)
					held_time = now;
				res.code = ST_PASSED;
			end else begin
				rated = held_cfg.rated_value;
				mag = rated[VALUE_W-1] ? (~rated + 1'b1) : rated;
				product = mag;
				product = product * held_cfg.slew_rate;
				product = product * elapsed;
				quotient = product / RATE_SCALE;
				if (quotient > VALUE_MAX)
					step = VALUE_MAX;
				else
					step = longint'(quotient[VALUE_W-1:0]);
				cur = held_value;
				tgt = target;
				// move toward the target, never past it
				if (tgt < cur) begin
					nv = cur - step;
					if (nv <= tgt)
						nv = tgt;
				end else begin
					nv = cur + step;
					if (nv >= tgt)
						nv = tgt;
				end
				held_value = nv[VALUE_W-1:0];
				if (!test_mode)
					held_time = now;
				res.code = ST_SLEWED;
			end
		end
		res.value = held_value;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		slew_result_t want;
		if (!arst_n) begin
			held_cfg.rated_value = '0;
			held_cfg.slew_rate = '0;
			held_cfg.enable = 1'b1;
			held_cfg.fixed_elapsed_ms = '0;
			held_time = '0;
			held_time_valid = 1'b0;
			held_value = '0;
			expected_q.delete();
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[CFG_ADDR_W-1:2]))
					REG_RATED_VALUE:   held_cfg.rated_value = pwdata[VALUE_W-1:0];
					REG_SLEW_RATE:     held_cfg.slew_rate = pwdata[RATE_W-1:0];
					REG_ENABLE:        held_cfg.enable = pwdata[0];
					REG_FIXED_ELAPSED: held_cfg.fixed_elapsed_ms = pwdata[TIME_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				case (status)
					ST_SLEWED:   slewed_seen <= slewed_seen + 1;
					ST_CAPTURED: captured_seen <= captured_seen + 1;
					ST_BAD_TIME: bad_time_seen <= bad_time_seen + 1;
					default:     passed_seen <= passed_seen + 1;
				endcase
				if (expected_q.size() == 0) begin
					if (mismatches < REPORT_LIMIT)
						$display("%0t: result with no request outstanding: value %0d status %0d",
							$time, output_value, status);
					mismatches <= mismatches + 1;
				end else begin
					want = expected_q.pop_front();
					if (output_value !== want.value || status !== want.code) begin
						if (mismatches < REPORT_LIMIT)
							$display("%0t: mismatch: expected value %0d status %0d, got value %0d status %0d",
								$time, want.value, want.code, output_value, status);
						mismatches <= mismatches + 1;
					end
				end
			end
			if (in_valid && !in_stall)
				expected_q.push_back(slew_next(timestamp_ms, setpoint));
			pending <= expected_q.size();
		end
	end

endmodule

[tb/timed_slew_rate_limiter_core_test.sv]
// top of the slew-rate limiter test: clock, reset, request and register stimulus, verdict
`timescale 1ns / 1ps

module timed_slew_rate_limiter_core_test;
	import tsrl_pkg::*;

	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 119;
	localparam int MAX_GAP         = 12;
	// well past the slowest legal run
	localparam longint RUN_LIMIT_NS = 64'd8_000_000;

	logic                         clk;
	logic                         arst_n       = 1'b0;
	logic                         in_valid     = 1'b0;
	logic                         in_stall;
	logic [TIME_W-1:0]            timestamp_ms = '0;
	logic signed [VALUE_W-1:0]    setpoint     = '0;
	logic                         out_valid;
	logic                         out_stall    = 1'b0;
	logic signed [VALUE_W-1:0]    output_value;
	logic [STATUS_W-1:0]          status;
	logic                         psel         = 1'b0;
	logic                         penable      = 1'b0;
	logic                         pwrite       = 1'b0;
	logic [CFG_ADDR_W-1:0]        paddr        = '0;
	logic [CFG_DATA_W-1:0]        pwdata       = '0;
	logic [CFG_DATA_W-1:0]        prdata;
	logic                         pready;

	int mismatches;
	int pending;
	int slewed_seen;
	int bad_time_seen;
	int passed_seen;
	int captured_seen;

	// idling knobs, changed only between phases, then run counters
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int requests_sent  = 0;
	int cfg_writes     = 0;

	timed_slew_rate_limiter_core dut (.*);

	slew_result_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// receiver side: a fresh stall decision every cycle
	always @(posedge clk)
		out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);

	// hard stop in case the block hangs
	initial begin
		#(RUN_LIMIT_NS);
		$display("timed_slew_rate_limiter_core_test failed");
		$finish;
	end

	// one apb write: setup, access, then a cycle with psel low so that
	// back-to-back writes never raise and lower psel in the same step
	task automatic cfg_write(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		cfg_writes++;
	endtask

	// offer one request and hold it until the block takes it; valid stays
	// high into the next request unless a random gap is drawn
	task automatic put_request(input logic [TIME_W-1:0] ts,
			input logic signed [VALUE_W-1:0] sp);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		timestamp_ms <= ts;
		setpoint     <= sp;
		do @(posedge clk); while (in_stall);
		requests_sent++;
	endtask

	// stop sending and wait until every result has come back
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	initial begin
		logic [TIME_W-1:0]         now_ms;
		logic [TIME_W-1:0]         ts;
		logic signed [VALUE_W-1:0] sp;
		logic signed [VALUE_W-1:0] sp_base;
		logic [VALUE_W-1:0]        rated;
		logic [RATE_W-1:0]         rate;
		logic                      en;
		logic [TIME_W-1:0]         fixed_ms;
		int                        kind;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed part, reset settings: rated 0, rate 0, enabled ----
		put_request(32'd1000, 32'sd12345);          // first request only captures time
		put_request(32'd2000, 32'sd12345);          // zero rated value, no movement
		put_request(32'd2000, -32'sd7);             // zero elapsed time
		put_request(32'd1500, -32'sd7);             // time running backward
		drain();

		// 100 percent of 1e6 per second: 1000 units per ms
		cfg_write(REG_RATED_VALUE, 32'd1_000_000);
		cfg_write(REG_SLEW_RATE, 32'd25600);
		put_request(32'd1510, 32'sd100000);         // partial step up
		put_request(32'd1600, 32'sd100000);         // step reaches the distance, lands on target
		put_request(32'd1601, -32'sd100000);        // step down
		drain();

		// most negative rated value and largest rate: magnitude taken, step saturates
		cfg_write(REG_RATED_VALUE, 32'h8000_0000);
		cfg_write(REG_SLEW_RATE, 32'h0000_FFFF);
		put_request(32'hFFFF_FFFF, 32'sh8000_0000);
		put_request(32'h0000_0000, 32'sh7FFF_FFFF); // backward again
		put_request(32'h0000_0001, 32'sh7FFF_FFFF); // one ms, large but bounded step
		put_request(32'hFFFF_FFFF, 32'sh7FFF_FFFF);
		drain();

		// disabled: setpoint passes straight through, bad time still reported
		cfg_write(REG_ENABLE, 32'd0);
		put_request(32'd100, -32'sd5);              // backward, re-bases time
		put_request(32'd200, -32'sd5);
		put_request(32'd200, 32'sh8000_0000);
		put_request(32'd300, 32'sh8000_0000);
		drain();

		// test mode with the largest fixed elapsed time: timestamps ignored
		cfg_write(REG_ENABLE, 32'd1);
		cfg_write(REG_RATED_VALUE, 32'h7FFF_FFFF);
		cfg_write(REG_FIXED_ELAPSED, 32'hFFFF_FFFF);
		put_request(32'd0, 32'sd0);
		put_request(32'd0, 32'sh5555_AAAA);         // same timestamp is fine in test mode
		drain();

		// test mode, one ms at 1 percent per second
		cfg_write(REG_FIXED_ELAPSED, 32'd1);
		cfg_write(REG_SLEW_RATE, 32'd256);
		put_request(32'd0, 32'sh7FFF_FFFF);
		drain();

		// test mode while disabled: stored time must stay frozen
		cfg_write(REG_ENABLE, 32'd0);
		put_request(32'd0, 32'sd77);
		drain();

		// back to measured time against the frozen stamp
		cfg_write(REG_FIXED_ELAPSED, 32'd0);
		cfg_write(REG_ENABLE, 32'd1);
		cfg_write(REG_SLEW_RATE, 32'd0);
		put_request(32'd400, 32'sd9);

		// ---- random part: one setting and one idling pattern per phase ----
		now_ms  = 32'd400;
		sp_base = '0;
		for (int p = 0; p < PHASES; p++) begin
			drain();
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
				default: begin send_idle_pct = 36; recv_stall_pct = 36; end
			endcase

			// random magnitude over every scale, random sign
			rated = $urandom >> $urandom_range(31);
			if ($urandom_range(1))
				rated = -rated;
			rate     = RATE_W'($urandom);
			en       = 1'b1;
			fixed_ms = '0;
			case (p)
				0: begin rated = 32'd1_000_000; rate = 16'd25600; end
				1: begin rated = 32'h8000_0000; rate = 16'hFFFF; end
				2: en = 1'b0;
				3: fixed_ms = $urandom_range(1, 200);
				4: rate = 16'd1;                     // very slow crawl
				5: fixed_ms = $urandom;
				6: rated = '0;
				default: begin
					rated    = $urandom;
					en       = 1'($urandom_range(1));
					fixed_ms = ($urandom_range(2) == 0) ? $urandom_range(1, 1000) : '0;
				end
			endcase
			cfg_write(REG_RATED_VALUE, rated);
			cfg_write(REG_SLEW_RATE, {{(CFG_DATA_W-RATE_W){1'b0}}, rate});
			cfg_write(REG_ENABLE, {{(CFG_DATA_W-1){1'b0}}, en});
			cfg_write(REG_FIXED_ELAPSED, fixed_ms);

			repeat (ITEMS_PER_PHASE) begin
				// target drifts around a base that jumps now and then
				if ($urandom_range(15) == 0) begin
					sp_base = $urandom >> $urandom_range(31);
					if ($urandom_range(1))
						sp_base = -sp_base;
				end
				kind = $urandom_range(99);
				if (kind < 65)
					ts = now_ms + (($urandom_range(3) == 0) ? $urandom_range(1, 100000)
						: $urandom_range(1, 300));
				else if (kind < 77)
					ts = now_ms;                              // zero elapsed
				else if (kind < 87)
					ts = now_ms - $urandom_range(1, 5000);    // backward
				else
					ts = $urandom;                            // noise
				if ($urandom_range(9) == 0)
					sp = $urandom;
				else
					sp = sp_base + $signed($urandom_range(0, 4000)) - 32'sd2000;
				put_request(ts, sp);
				now_ms = ts;
			end
		end

		drain();
		// quiet period longer than a slewed request, to catch stray results
		repeat (150) @(posedge clk);

		$display("covered %0d requests over %0d idling phases with %0d register writes",
			requests_sent, PHASES, cfg_writes);
		$display("results seen: %0d slewed, %0d bad time, %0d passed through, %0d time captured",
			slewed_seen, bad_time_seen, passed_seen, captured_seen);
		if (mismatches == 0 && pending == 0)
			$display("timed_slew_rate_limiter_core_test passed");
		else
			$display("timed_slew_rate_limiter_core_test failed");
		$finish;
	end

endmodule
